// File: rtl/cesc_pkg.sv
// cesc_pkg: shared types, character codes and helpers for the escape decoder
// depends on nothing; used by every other file of the decoder
package cesc_pkg;

  // widths of the result fields
  localparam int unsigned ByteW = 8;
  localparam int unsigned CountW = 15;

  // consumed count saturates here
  localparam logic [CountW-1:0] MaxCount = 15'd32767;

  // result queue geometry
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw = $clog2(FifoDepth);

  // configuration register indexes
  localparam logic CfgStop = 1'b0;
  localparam logic CfgKept = 1'b1;

  // result kinds
  localparam logic KindChar = 1'b0;
  localparam logic KindEnd = 1'b1;

  // character codes
  localparam logic [ByteW-1:0] ChNul = 8'h00;
  localparam logic [ByteW-1:0] ChTab = 8'h09;
  localparam logic [ByteW-1:0] ChLf = 8'h0A;
  localparam logic [ByteW-1:0] ChCr = 8'h0D;
  localparam logic [ByteW-1:0] ChSpace = 8'h20;
  localparam logic [ByteW-1:0] ChQuote = 8'h22;
  localparam logic [ByteW-1:0] ChBslash = 8'h5C;
  localparam logic [ByteW-1:0] ChLowerN = 8'h6E;
  localparam logic [ByteW-1:0] ChLowerR = 8'h72;
  localparam logic [ByteW-1:0] ChLowerT = 8'h74;
  localparam logic [ByteW-1:0] ChLowerX = 8'h78;

  // one result word
  typedef struct packed {
    logic              result_kind;
    logic [ByteW-1:0]  decoded_byte;
    logic [CountW-1:0] consumed_count;
    logic              last_of_run;
  } result_t;

  // up to two result words produced by one text byte
  typedef struct packed {
    logic [1:0] num;
    result_t    first;
    result_t    second;
  } push_t;

  // saturating increment of the consumed count
  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] c);
    sat_inc = (c == MaxCount) ? c : c + CountW'(1);
  endfunction

  // hex digit decode: bit 4 set when the byte is a hex digit
  function automatic logic [4:0] hex_digit(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] d;
    d = 8'h00;
    hex_digit = 5'h00;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = b - 8'h30;
      hex_digit = {1'b1, d[3:0]};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = b - 8'h37;
      hex_digit = {1'b1, d[3:0]};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = b - 8'h57;
      hex_digit = {1'b1, d[3:0]};
    end
  endfunction

endpackage

// File: rtl/cesc_if.sv
// cesc_text_if and cesc_result_if: valid/ready channels of the escape decoder
// depends on cesc_pkg for field widths
interface cesc_text_if;
  logic                     valid;
  logic                     ready;
  logic [cesc_pkg::ByteW-1:0] text_byte;

  modport source (output valid, output text_byte, input ready);
  modport sink (input valid, input text_byte, output ready);
endinterface

interface cesc_result_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [cesc_pkg::ByteW-1:0]  decoded_byte;
  logic [cesc_pkg::CountW-1:0] consumed_count;
  logic                        last_of_run;

  modport source (output valid, output result_kind, output decoded_byte,
                  output consumed_count, output last_of_run, input ready);
  modport sink (input valid, input result_kind, input decoded_byte,
                input consumed_count, input last_of_run, output ready);
endinterface

// File: rtl/cesc_decode.sv
// cesc_decode: per-byte escape decode state machine, makes up to two result words
// depends on cesc_pkg
module cesc_decode (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic [cesc_pkg::ByteW-1:0]  text_byte_i,
  input  logic                        stop_i,
  input  logic [cesc_pkg::ByteW-1:0]  kept_i,
  output cesc_pkg::push_t             push_o
);

  typedef enum logic [1:0] {ModeNormal, ModeEscape, ModeHex, ModeSkip} mode_e;

  mode_e                       mode_q, mode_d;
  logic [cesc_pkg::ByteW-1:0]  acc_q, acc_d;
  logic [1:0]                  digits_q, digits_d;
  logic [cesc_pkg::CountW-1:0] cnt_q, cnt_d;

  logic [cesc_pkg::CountW-1:0] cnt_inc;
  logic [4:0]                  hex_w;
  logic [cesc_pkg::ByteW-1:0]  acc_shift;
  logic [1:0]                  digits_inc;

  // plain byte handling
  mode_e                       nb_mode;
  logic [cesc_pkg::CountW-1:0] nb_cnt;
  logic                        nb_emit;
  cesc_pkg::result_t           nb_res;

  // result slots: a is a flushed hex value, b the byte's own result
  logic              a_vld, b_vld;
  cesc_pkg::result_t a_res, b_res;

  assign cnt_inc    = cesc_pkg::sat_inc(cnt_q);
  assign hex_w      = cesc_pkg::hex_digit(text_byte_i);
  assign acc_shift  = {acc_q[3:0], hex_w[3:0]};
  assign digits_inc = digits_q + 2'd1;

  // unescaped byte, also used after a hex escape ends on a non-hex byte
  always_comb begin
    nb_mode = ModeNormal;
    nb_cnt  = cnt_inc;
    nb_emit = 1'b0;
    nb_res  = '0;
    if (text_byte_i == cesc_pkg::ChNul) begin
      nb_cnt = '0;
      nb_emit = 1'b1;
      nb_res.result_kind = cesc_pkg::KindEnd;
      nb_res.consumed_count = cnt_inc;
    end else if (text_byte_i == cesc_pkg::ChBslash) begin
      nb_mode = ModeEscape;
    end else if (stop_i && (text_byte_i == cesc_pkg::ChQuote ||
                            text_byte_i < cesc_pkg::ChSpace)) begin
      nb_mode = ModeSkip;
      nb_cnt = '0;
      nb_emit = 1'b1;
      nb_res.result_kind = cesc_pkg::KindEnd;
      nb_res.consumed_count = cnt_q;
    end else if (text_byte_i < cesc_pkg::ChSpace && text_byte_i != kept_i) begin
      nb_emit = 1'b0;
    end else begin
      nb_emit = 1'b1;
      nb_res.result_kind = cesc_pkg::KindChar;
      nb_res.decoded_byte = text_byte_i;
    end
  end

  // next state and result slots
  always_comb begin
    mode_d   = mode_q;
    acc_d    = acc_q;
    digits_d = digits_q;
    cnt_d    = cnt_q;
    a_vld    = 1'b0;
    a_res    = '0;
    b_vld    = 1'b0;
    b_res    = '0;
    unique case (mode_q)
      ModeEscape: begin
        cnt_d = cnt_inc;
        if (text_byte_i == cesc_pkg::ChNul) begin
          mode_d = ModeNormal;
          cnt_d = '0;
          b_vld = 1'b1;
          b_res.result_kind = cesc_pkg::KindEnd;
          b_res.consumed_count = cnt_inc;
        end else if (text_byte_i == cesc_pkg::ChLowerX) begin
          mode_d = ModeHex;
          acc_d = '0;
          digits_d = '0;
        end else begin
          mode_d = ModeNormal;
          b_res.result_kind = cesc_pkg::KindChar;
          b_vld = (text_byte_i != cesc_pkg::ChLf) && (text_byte_i != cesc_pkg::ChCr);
          if (text_byte_i == cesc_pkg::ChLowerT) begin
            b_res.decoded_byte = cesc_pkg::ChTab;
          end else if (text_byte_i == cesc_pkg::ChLowerN) begin
            b_res.decoded_byte = cesc_pkg::ChLf;
          end else if (text_byte_i == cesc_pkg::ChLowerR) begin
            b_res.decoded_byte = cesc_pkg::ChCr;
          end else begin
            b_res.decoded_byte = text_byte_i;
          end
        end
      end
      ModeHex: begin
        if (hex_w[4]) begin
          cnt_d = cnt_inc;
          acc_d = acc_shift;
          digits_d = digits_inc;
          if (digits_inc >= 2'd2) begin
            b_vld = (acc_shift != '0);
            b_res.result_kind = cesc_pkg::KindChar;
            b_res.decoded_byte = acc_shift;
            mode_d = ModeNormal;
            acc_d = '0;
            digits_d = '0;
          end
        end else begin
          // flush the value so far, then treat the byte as unescaped
          a_vld = (acc_q != '0);
          a_res.result_kind = cesc_pkg::KindChar;
          a_res.decoded_byte = acc_q;
          acc_d = '0;
          digits_d = '0;
          mode_d = nb_mode;
          cnt_d = nb_cnt;
          b_vld = nb_emit;
          b_res = nb_res;
        end
      end
      ModeSkip: begin
        if (text_byte_i == cesc_pkg::ChNul) begin
          mode_d = ModeNormal;
          acc_d = '0;
          digits_d = '0;
          cnt_d = '0;
        end
      end
      default: begin
        mode_d = nb_mode;
        cnt_d = nb_cnt;
        b_vld = nb_emit;
        b_res = nb_res;
      end
    endcase
  end

  // order the slots and mark the final word of the byte
  always_comb begin
    push_o = '0;
    if (step_i) begin
      if (a_vld && b_vld) begin
        push_o.num = 2'd2;
        push_o.first = a_res;
        push_o.second = b_res;
        push_o.second.last_of_run = 1'b1;
      end else if (a_vld) begin
        push_o.num = 2'd1;
        push_o.first = a_res;
        push_o.first.last_of_run = 1'b1;
      end else if (b_vld) begin
        push_o.num = 2'd1;
        push_o.first = b_res;
        push_o.first.last_of_run = 1'b1;
      end
    end
  end

  // decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeNormal;
      acc_q    <= '0;
      digits_q <= '0;
      cnt_q    <= '0;
    end else if (step_i) begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      digits_q <= digits_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// File: rtl/cesc_result_fifo.sv
// cesc_result_fifo: small result queue taking up to two words a cycle
// depends on cesc_pkg
module cesc_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cesc_pkg::push_t   push_i,
  input  logic              pop_i,
  output logic              valid_o,
  output logic              room_o,
  output cesc_pkg::result_t head_o
);

  localparam int unsigned CntW = cesc_pkg::FifoAw + 1;

  cesc_pkg::result_t           mem_q [cesc_pkg::FifoDepth];
  logic [cesc_pkg::FifoAw-1:0] wr_q, rd_q;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic                        do_pop;

  assign valid_o = (cnt_q != '0);
  // room for the worst case of two words
  assign room_o  = (cnt_q <= CntW'(cesc_pkg::FifoDepth - 2));
  assign head_o  = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;
  assign cnt_d   = cnt_q + CntW'(push_i.num) - CntW'(do_pop);

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_q + cesc_pkg::FifoAw'(1)] <= push_i.second;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + cesc_pkg::FifoAw'(push_i.num);
      rd_q  <= rd_q + cesc_pkg::FifoAw'(do_pop);
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/c_escape_decoder_top.sv
// c_escape_decoder_top: escaped string decoder, configuration registers and queue
// depends on cesc_pkg, cesc_if, cesc_decode and cesc_result_fifo
//
//   channel    dir  word
//   text_i     in   text_byte
//   result_o   out  result_kind, decoded_byte, consumed_count, last_of_run
//   cfg_*_i    in   register index and data, write on cfg_we_i
//
// one text byte is decoded in the cycle it is accepted; its results land in a
// four-word queue and leave from there, at most one word per cycle
// a byte may give two words (flushed hex value then its own), so sustained
// input is one byte per cycle while results are taken at least as fast
// text_i.ready drops while fewer than two queue slots are free
// reset empties the queue, clears the decode state and both registers
module c_escape_decoder_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cesc_pkg::ByteW-1:0] cfg_data_i,
  cesc_text_if.sink                  text_i,
  cesc_result_if.source              result_o
);

  logic                       stop_q;
  logic [cesc_pkg::ByteW-1:0] kept_q;
  logic                       room;
  logic                       step;
  cesc_pkg::push_t            push;
  cesc_pkg::result_t          head;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_q <= 1'b0;
      kept_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cesc_pkg::CfgStop: stop_q <= cfg_data_i[0];
        cesc_pkg::CfgKept: kept_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input handshake
  assign text_i.ready = room;
  assign step         = text_i.valid && room;

  cesc_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .text_byte_i (text_i.text_byte),
    .stop_i      (stop_q),
    .kept_i      (kept_q),
    .push_o      (push)
  );

  cesc_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (result_o.ready),
    .valid_o (result_o.valid),
    .room_o  (room),
    .head_o  (head)
  );

  // output word
  assign result_o.result_kind    = head.result_kind;
  assign result_o.decoded_byte   = head.decoded_byte;
  assign result_o.consumed_count = head.consumed_count;
  assign result_o.last_of_run    = head.last_of_run;

`ifndef SYNTHESIS
  // an end word is always the last word of its byte
  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.result_kind == cesc_pkg::KindEnd
      |-> result_o.last_of_run)
    else $error("end word without last_of_run");

  // character words carry no count
  a_char_no_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.result_kind == cesc_pkg::KindChar
      |-> result_o.consumed_count == '0)
    else $error("character word with nonzero count");

  // end words carry no character
  a_end_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.result_kind == cesc_pkg::KindEnd
      |-> result_o.decoded_byte == '0)
    else $error("end word with nonzero byte");

  // a pushed pair always closes on its second word only
  a_pair_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.num == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
    else $error("bad last_of_run on a word pair");
`endif

endmodule

// File: sim/c_escape_decoder_checker.sv
// c_escape_decoder_checker: predicts the result words of the escape decoder from
// accepted text bytes and register writes, and compares them with the words that leave it
// depends on cesc_pkg and the channel interfaces of cesc_if
module c_escape_decoder_checker
  import cesc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ByteW-1:0] cfg_data_i,
  cesc_text_if             text_i,
  cesc_result_if           result_i,
  output int unsigned      errors_o,
  output int unsigned      pending_o,
  output int unsigned      live_bytes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    ModeNormal,
    ModeEscape,
    ModeHex,
    ModeSkip
  } mode_e;

  // shadow registers and decode state
  logic              stop_en;
  logic [ByteW-1:0]  kept_ch;
  mode_e             mode;
  logic [ByteW-1:0]  hex_acc;
  logic [1:0]        hex_cnt;
  logic [CountW-1:0] str_count;

  // words still owed by the decoder, oldest first
  result_t           owed_words[$];
  int unsigned       reported;

  // bit 4 flags a hex digit, bits 3:0 carry its value
  function automatic logic [4:0] nibble_of(input logic [ByteW-1:0] b);
    logic [4:0] r;
    r = 5'h00;
    if (b inside {[8'h30:8'h39]}) r = {1'b1, b[3:0]};
    else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) r = {1'b1, b[3:0] + 4'd9};
    return r;
  endfunction

  function automatic void bump_count();
    if (str_count != MaxCount) str_count = str_count + 1'b1;
  endfunction

  function automatic void owe_word(input logic kind, input logic [ByteW-1:0] b);
    result_t w;
    w.result_kind    = kind;
    w.decoded_byte   = b;
    w.consumed_count = (kind == KindEnd) ? str_count : '0;
    w.last_of_run    = 1'b0;
    owed_words.push_back(w);
  endfunction

  function automatic void clear_string();
    mode      = ModeNormal;
    hex_acc   = '0;
    hex_cnt   = '0;
    str_count = '0;
  endfunction

  // close a hex escape, a zero value gives no character
  function automatic void flush_hex();
    if (hex_acc != '0) owe_word(KindChar, hex_acc);
    mode    = ModeNormal;
    hex_acc = '0;
    hex_cnt = '0;
  endfunction

  // byte outside any escape
  function automatic void plain_byte(input logic [ByteW-1:0] b);
    if (b == ChNul) begin
      bump_count();
      owe_word(KindEnd, ChNul);
      clear_string();
    end else if (b == ChBslash) begin
      bump_count();
      mode = ModeEscape;
    end else if (stop_en && (b == ChQuote || b < ChSpace)) begin
      // stop byte is not counted, rest of the string is skipped
      owe_word(KindEnd, ChNul);
      clear_string();
      mode = ModeSkip;
    end else if (b < ChSpace && b != kept_ch) begin
      bump_count();
    end else begin
      bump_count();
      owe_word(KindChar, b);
    end
  endfunction

  // one accepted text byte
  function automatic void decode_byte(input logic [ByteW-1:0] b);
    logic [4:0]  nib;
    int unsigned queued;
    result_t     w;
    queued = owed_words.size();
    case (mode)
      ModeEscape: begin
        bump_count();
        if (b == ChNul) begin
          owe_word(KindEnd, ChNul);
          clear_string();
        end else if (b == ChLowerX) begin
          mode    = ModeHex;
          hex_acc = '0;
          hex_cnt = '0;
        end else begin
          mode = ModeNormal;
          if (b == ChLowerT) owe_word(KindChar, ChTab);
          else if (b == ChLowerN) owe_word(KindChar, ChLf);
          else if (b == ChLowerR) owe_word(KindChar, ChCr);
          else if (b != ChLf && b != ChCr) owe_word(KindChar, b);
        end
      end
      ModeHex: begin
        nib = nibble_of(b);
        if (nib[4]) begin
          bump_count();
          hex_acc = {hex_acc[3:0], nib[3:0]};
          hex_cnt = hex_cnt + 1'b1;
          if (hex_cnt >= 2'd2) flush_hex();
        end else begin
          flush_hex();
          plain_byte(b);
        end
      end
      ModeSkip: begin
        if (b == ChNul) clear_string();
      end
      default: plain_byte(b);
    endcase
    // mark the final word of this byte
    if (owed_words.size() > queued) begin
      w = owed_words.pop_back();
      w.last_of_run = 1'b1;
      owed_words.push_back(w);
    end
  endfunction

  // compare one word taken from the decoder with the oldest owed word
  function automatic void check_word();
    result_t got;
    result_t want;
    got.result_kind    = result_i.result_kind;
    got.decoded_byte   = result_i.decoded_byte;
    got.consumed_count = result_i.consumed_count;
    got.last_of_run    = result_i.last_of_run;
    if (owed_words.size() == 0) begin
      errors_o++;
      if (reported < 10) begin
        reported++;
        $display("%0t: unexpected word: kind %0d byte %02h count %0d last %0d", $time,
                 got.result_kind, got.decoded_byte, got.consumed_count, got.last_of_run);
      end
    end else begin
      want = owed_words.pop_front();
      if (got.result_kind !== want.result_kind || got.decoded_byte !== want.decoded_byte ||
          got.consumed_count !== want.consumed_count ||
          got.last_of_run !== want.last_of_run) begin
        errors_o++;
        if (reported < 10) begin
          reported++;
          $display("%0t: word mismatch: expected kind %0d byte %02h count %0d last %0d",
                   $time, want.result_kind, want.decoded_byte, want.consumed_count,
                   want.last_of_run);
          $display("%0t:                got kind %0d byte %02h count %0d last %0d",
                   $time, got.result_kind, got.decoded_byte, got.consumed_count,
                   got.last_of_run);
        end
      end
    end
  endfunction

  // outgoing words first, then the incoming byte, then a register write
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stop_en = 1'b0;
      kept_ch = '0;
      clear_string();
      owed_words.delete();
      reported     = 0;
      errors_o     = 0;
      live_bytes_o = 0;
    end else begin
      if (result_i.valid && result_i.ready) check_word();
      if (text_i.valid && text_i.ready) begin
        if (mode != ModeSkip) live_bytes_o++;
        decode_byte(text_i.text_byte);
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgStop) stop_en = cfg_data_i[0];
        else kept_ch = cfg_data_i;
      end
    end
    pending_o = owed_words.size();
  end

endmodule

// File: sim/c_escape_decoder_top_tb.sv
// c_escape_decoder_top_tb: drives text bytes and register writes into the escape decoder,
// stalls the result side, and gives the verdict from the checker's error count
// depends on cesc_pkg, cesc_if, c_escape_decoder_top and c_escape_decoder_checker
module c_escape_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cesc_pkg::*;

  localparam int unsigned HoldCycles = 200;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic             cfg_idx;
  logic [ByteW-1:0] cfg_data;

  cesc_text_if   text_ch ();
  cesc_result_if result_ch ();

  int unsigned errors;
  int unsigned pending;
  int unsigned live_bytes;

  // sender and receiver pacing
  int unsigned stall_pct;
  int unsigned gap_max;
  int unsigned burst_left;
  bit          hold_armed;
  bit          hold_done;

  // bytes of the string being sent
  logic [ByteW-1:0] text_q[$];

  c_escape_decoder_top i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .text_i     (text_ch),
    .result_o   (result_ch)
  );

  c_escape_decoder_checker i_checker (
    .clk_i,
    .rst_ni,
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .text_i       (text_ch),
    .result_i     (result_ch),
    .errors_o     (errors),
    .pending_o    (pending),
    .live_bytes_o (live_bytes)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // run limit
  initial begin
    #1_000_000;
    $display("c_escape_decoder_top_tb: done, errors");
    $finish;
  end

  // result side: one long hold-off when armed, random stalls otherwise
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_armed && !hold_done) begin
        result_ch.ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        result_ch.ready = ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  // offer one byte, called and returning at a falling edge
  task automatic send_byte(input logic [ByteW-1:0] b);
    if (burst_left == 0) begin
      if (gap_max != 0) begin
        text_ch.valid = 1'b0;
        repeat ($urandom_range(1, gap_max)) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    text_ch.valid     = 1'b1;
    text_ch.text_byte = b;
    do @(posedge clk_i); while (!text_ch.ready);
    @(negedge clk_i);
    burst_left--;
  endtask

  task automatic send_queued();
    foreach (text_q[i]) send_byte(text_q[i]);
  endtask

  // wait until every owed word has come out, then let the decoder go quiet
  task automatic settle();
    int unsigned guard;
    text_ch.valid = 1'b0;
    guard = 0;
    while (pending != 0 && guard < 5000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [ByteW-1:0] val);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val;
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic logic [ByteW-1:0] rand_hex();
    string digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  // one string with random content, now and then raw noise instead
  function automatic void build_text(input logic [ByteW-1:0] kept);
    logic [ByteW-1:0] b;
    text_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 16)) text_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 10)) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          b = 8'($urandom_range(8'h20, 8'h7E));
          text_q.push_back((b == ChBslash) ? ChQuote : b);
        end
        4: text_q.push_back(8'($urandom_range(8'h80, 8'hFF)));
        5: text_q.push_back(8'($urandom_range(8'h01, 8'h1F)));
        6: text_q.push_back(kept);
        7, 8: begin
          text_q.push_back(ChBslash);
          case ($urandom_range(0, 7))
            0: text_q.push_back(ChLowerT);
            1: text_q.push_back(ChLowerN);
            2: text_q.push_back(ChLowerR);
            3: text_q.push_back(ChBslash);
            4: text_q.push_back(ChLf);
            5: text_q.push_back(ChCr);
            6: text_q.push_back(ChQuote);
            default: text_q.push_back(8'($urandom_range(1, 255)));
          endcase
        end
        default: begin
          // hex escape with zero, one or two digits, sometimes a digit after it
          text_q.push_back(ChBslash);
          text_q.push_back(ChLowerX);
          repeat ($urandom_range(0, 2)) text_q.push_back(rand_hex());
          if ($urandom_range(0, 2) == 0) text_q.push_back(rand_hex());
        end
      endcase
    end
    // escape cut short by the terminator
    if ($urandom_range(0, 14) == 0) text_q.push_back(ChBslash);
    text_q.push_back(ChNul);
  endfunction

  // one register setting with its own pacing, ended by a terminator
  task automatic random_phase(input logic stop, input logic [ByteW-1:0] kept,
                              input int unsigned stall, input int unsigned gaps,
                              input int unsigned quota, input bit hold);
    int unsigned target;
    settle();
    write_reg(CfgStop, {7'b0, stop});
    write_reg(CfgKept, kept);
    stall_pct  = stall;
    gap_max    = gaps;
    hold_armed = hold;
    target     = live_bytes + quota;
    while (live_bytes < target) begin
      build_text(kept);
      send_queued();
    end
    send_byte(ChNul);
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CfgStop;
    cfg_data          = '0;
    text_ch.valid     = 1'b0;
    text_ch.text_byte = '0;
    stall_pct         = 25;
    gap_max           = 4;
    burst_left        = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers at reset: plain, dropped control, escapes, continuation, hex cases,
    // then a backslash right before the terminator
    text_q = '{8'h41, 8'h01, ChBslash, ChLowerN, ChBslash, ChLf, ChBslash, ChQuote,
               ChBslash, ChLowerX, 8'h34, 8'h31, ChBslash, ChLowerX, 8'h37, 8'h67,
               ChBslash, ChLowerX, 8'h30, 8'h30, ChNul, ChBslash, ChNul};
    send_queued();

    // stop mode: quote stops, skip to terminator, escaped quote passes, control stops
    settle();
    write_reg(CfgStop, 8'h01);
    write_reg(CfgKept, 8'hFF);
    text_q = '{8'h61, ChQuote, 8'h62, ChNul, ChBslash, ChQuote, 8'h1F, ChNul};
    send_queued();

    // random strings under several settings
    random_phase(1'b0, 8'h00, 0, 0, 150, 1'b0);
    random_phase(1'b1, 8'h1F, 30, 6, 150, 1'b0);
    random_phase(1'b0, 8'hFF, 50, 3, 150, 1'b0);
    random_phase(1'b0, 8'h0A, 20, 0, 150, 1'b1);
    random_phase(1'b1, 8'h00, 60, 8, 150, 1'b1);
    random_phase(1'b0, 8'($urandom_range(1, 8'h1F)), 10, 2, 150, 1'b1);
    random_phase(1'b1, 8'hFF, 0, 0, 100, 1'b1);
    random_phase(1'b0, 8'h09, 40, 4, 100, 1'b1);

    settle();
    if (errors == 0 && pending == 0) begin
      $display("c_escape_decoder_top_tb: done, clean");
    end else begin
      $display("c_escape_decoder_top_tb: done, errors");
    end
    $finish;
  end

endmodule
